// ===== rtl/core/complex_arith_unit_assert.svh =====
// Assertion macros for the complex arithmetic unit checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CAU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arith_unit: check failed");

// Check cons in the cycle after ante.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_arith_unit: check failed");

`endif

// ===== rtl/core/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef enum logic [2:0]
    {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_NEG  = 3'd5,
        OP_MAG  = 3'd6,
        OP_EQ   = 3'd7
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t   op;
        data_t a_re;
        data_t a_im;
        data_t b_re;
        data_t b_im;
    } in_item_t;

    typedef struct packed
    {
        data_t   res_re;
        data_t   res_im;
        logic    is_equal;
        status_t status;
    } out_item_t;

    typedef struct packed
    {
        op_t   op;
        data_t a_re;
        data_t a_im;
        data_t b_re;
        data_t b_im;
        logic  div_zero;
        logic  equal;
    } cls_item_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cau_front.sv =====
// Front end: accepts input items, classifies them and pushes them to the queue.
// Depends on cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cau_pkg::in_item_t   in_item,
    input  wire cau_pkg::fifo_stat_t fifo_stat,
    output logic                     push,
    output cau_pkg::cls_item_t       push_item
);
    import cau_pkg::*;

    logic dz;
    logic same;

    assign in_ready = rst_n && !fifo_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        dz   = (in_item.b_re == '0) && (in_item.b_im == '0);
        same = (in_item.a_re == in_item.b_re) && (in_item.a_im == in_item.b_im);
        push_item.op       = in_item.op;
        push_item.a_re     = in_item.a_re;
        push_item.a_im     = in_item.a_im;
        push_item.b_re     = in_item.b_re;
        push_item.b_im     = in_item.b_im;
        push_item.div_zero = dz;
        push_item.equal    = (in_item.op == OP_EQ) && same;
    end

    logic unused_clk;
    assign unused_clk = clk;

endmodule

`default_nettype wire

// ===== rtl/core/cau_queue.sv =====
// Short queue of classified items between front and back end.
// Depends on cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cau_pkg::cls_item_t push_item,
    input  wire logic               pop,
    output cau_pkg::cls_item_t      head,
    output cau_pkg::fifo_stat_t     stat
);
    import cau_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cls_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cau_back.sv =====
// Back end: pipelined products, sums, divider and root, saturation, output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cau_pkg::cls_item_t  head,
    input  wire cau_pkg::fifo_stat_t fifo_stat,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cau_pkg::out_item_t       out_item
);
    import cau_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int SX  = DW + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int MW  = PW;
    localparam int QW  = DW + 1;
    localparam int NW  = MW + FB;
    localparam int RW  = MW + 1;
    localparam int SQW = DW + 3;

    localparam logic [MW-1:0] MAXP_M = MW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [MW-1:0] MAXN_M = MW'(64'd1 << (DW - 1));
    localparam data_t         MAXP_D = DW'((64'd1 << (DW - 1)) - 64'd1);
    localparam data_t         MINN_D = DW'(64'd1 << (DW - 1));

    typedef struct packed
    {
        logic  sat;
        data_t val;
    } sres_t;

    typedef struct packed
    {
        op_t   op;
        logic  dz;
        logic  eq;
        data_t sre;
        data_t sim;
        logic  ssat;
    } hdr_t;

    typedef struct packed
    {
        hdr_t                  h;
        logic signed [PW-1:0]  p_rr;
        logic signed [PW-1:0]  p_ii;
        logic signed [PW-1:0]  p_ri;
        logic signed [PW-1:0]  p_ir;
        logic signed [PW-1:0]  q_rr;
        logic signed [PW-1:0]  q_ii;
    } s1_t;

    typedef struct packed
    {
        hdr_t                  h;
        logic signed [SW-1:0]  sum_re;
        logic signed [SW-1:0]  sum_im;
        logic [MW-1:0]         den;
    } s2_t;

    typedef struct packed
    {
        hdr_t          h;
        logic          neg_re;
        logic          neg_im;
        logic [MW-1:0] mag_re;
        logic [MW-1:0] mag_im;
        logic [MW-1:0] den;
    } s3_t;

    typedef struct packed
    {
        hdr_t           h;
        logic           neg_re;
        logic           neg_im;
        logic [MW-1:0]  mul_re;
        logic [MW-1:0]  mul_im;
        logic [MW-1:0]  den;
        logic           ovf_re;
        logic           ovf_im;
        logic [RW-1:0]  rem_re;
        logic [RW-1:0]  rem_im;
        logic [QW-1:0]  nlo_re;
        logic [QW-1:0]  nlo_im;
        logic [QW-1:0]  q_re;
        logic [QW-1:0]  q_im;
        logic [MW-1:0]  sq_v;
        logic [SQW-1:0] sq_rem;
        logic [DW-1:0]  sq_root;
    } st_t;

    function automatic sres_t sat_s(input logic signed [SX-1:0] v);
        sres_t r;
        if (v[SX-1] != v[SX-2])
        begin
            r.sat = 1'b1;
            r.val = v[SX-1] ? MINN_D : MAXP_D;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic sres_t sat_sm(input logic neg, input logic [MW-1:0] mag);
        sres_t         r;
        logic [MW-1:0] nm;
        nm = ~mag + MW'(1);
        if (!neg)
        begin
            r.sat = (mag > MAXP_M);
            r.val = r.sat ? MAXP_D : mag[DW-1:0];
        end
        else
        begin
            r.sat = (mag > MAXN_M);
            r.val = r.sat ? MINN_D : nm[DW-1:0];
        end
        return r;
    endfunction

    logic adv;
    logic out_valid_reg;
    out_item_t out_item_reg, out_item_next;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [QW:0] pvld_reg;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    st_t pipe_reg [QW+1];
    st_t pipe0_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && !fifo_stat.empty;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        sres_t sr;
        sres_t si;
        logic  is_mag;
        is_mag = (head.op == OP_MAG);
        sr = '0;
        si = '0;
        case (head.op)
            OP_ADD:
            begin
                sr = sat_s(SX'(head.a_re) + SX'(head.b_re));
                si = sat_s(SX'(head.a_im) + SX'(head.b_im));
            end
            OP_SUB:
            begin
                sr = sat_s(SX'(head.a_re) - SX'(head.b_re));
                si = sat_s(SX'(head.a_im) - SX'(head.b_im));
            end
            OP_CONJ:
            begin
                sr.val = head.a_re;
                si = sat_s(-SX'(head.a_im));
            end
            OP_NEG:
            begin
                sr = sat_s(-SX'(head.a_re));
                si = sat_s(-SX'(head.a_im));
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        s1_next.h.op   = head.op;
        s1_next.h.dz   = head.div_zero;
        s1_next.h.eq   = head.equal;
        s1_next.h.sre  = sr.val;
        s1_next.h.sim  = si.val;
        s1_next.h.ssat = sr.sat || si.sat;
        s1_next.p_rr   = PW'(head.a_re) * PW'(is_mag ? head.a_re : head.b_re);
        s1_next.p_ii   = PW'(head.a_im) * PW'(is_mag ? head.a_im : head.b_im);
        s1_next.p_ri   = PW'(head.a_re) * PW'(head.b_im);
        s1_next.p_ir   = PW'(head.a_im) * PW'(head.b_re);
        s1_next.q_rr   = PW'(head.b_re) * PW'(head.b_re);
        s1_next.q_ii   = PW'(head.b_im) * PW'(head.b_im);
    end

    always_comb
    begin
        s2_next.h = s1_reg.h;
        if (s1_reg.h.op == OP_MUL)
        begin
            s2_next.sum_re = SW'(s1_reg.p_rr) - SW'(s1_reg.p_ii);
            s2_next.sum_im = SW'(s1_reg.p_ri) + SW'(s1_reg.p_ir);
        end
        else
        begin
            s2_next.sum_re = SW'(s1_reg.p_rr) + SW'(s1_reg.p_ii);
            s2_next.sum_im = SW'(s1_reg.p_ir) - SW'(s1_reg.p_ri);
        end
        s2_next.den = MW'(s1_reg.q_rr) + MW'(s1_reg.q_ii);
    end

    always_comb
    begin
        logic signed [SW-1:0] nre;
        logic signed [SW-1:0] nim;
        nre = -s2_reg.sum_re;
        nim = -s2_reg.sum_im;
        s3_next.h      = s2_reg.h;
        s3_next.neg_re = s2_reg.sum_re[SW-1];
        s3_next.neg_im = s2_reg.sum_im[SW-1];
        s3_next.mag_re = s2_reg.sum_re[SW-1] ? nre[MW-1:0] : s2_reg.sum_re[MW-1:0];
        s3_next.mag_im = s2_reg.sum_im[SW-1] ? nim[MW-1:0] : s2_reg.sum_im[MW-1:0];
        s3_next.den    = s2_reg.den;
    end

    always_comb
    begin
        logic [NW-1:0] n_re;
        logic [NW-1:0] n_im;
        n_re = NW'(s3_reg.mag_re) << FB;
        n_im = NW'(s3_reg.mag_im) << FB;
        pipe0_next.h       = s3_reg.h;
        pipe0_next.neg_re  = s3_reg.neg_re;
        pipe0_next.neg_im  = s3_reg.neg_im;
        pipe0_next.mul_re  = s3_reg.mag_re >> FB;
        pipe0_next.mul_im  = s3_reg.mag_im >> FB;
        pipe0_next.den     = s3_reg.den;
        pipe0_next.rem_re  = RW'(n_re[NW-1:QW]);
        pipe0_next.rem_im  = RW'(n_im[NW-1:QW]);
        pipe0_next.ovf_re  = RW'(n_re[NW-1:QW]) >= RW'(s3_reg.den);
        pipe0_next.ovf_im  = RW'(n_im[NW-1:QW]) >= RW'(s3_reg.den);
        pipe0_next.nlo_re  = n_re[QW-1:0];
        pipe0_next.nlo_im  = n_im[QW-1:0];
        pipe0_next.q_re    = '0;
        pipe0_next.q_im    = '0;
        pipe0_next.sq_v    = s3_reg.mag_re;
        pipe0_next.sq_rem  = '0;
        pipe0_next.sq_root = '0;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        st_t            cur;
        st_t            nxt;
        logic [RW-1:0]  t_re, t_im;
        logic           ge_re, ge_im;
        logic [SQW-1:0] sq_rem_n;
        logic [DW-1:0]  sq_root_n;

        assign cur   = pipe_reg[k];
        assign t_re  = {cur.rem_re[RW-2:0], cur.nlo_re[QW-1-k]};
        assign t_im  = {cur.rem_im[RW-2:0], cur.nlo_im[QW-1-k]};
        assign ge_re = (t_re >= RW'(cur.den));
        assign ge_im = (t_im >= RW'(cur.den));

        if (k < DW)
        begin : g_sq
            logic [SQW-1:0] sh;
            logic [SQW-1:0] tt;
            logic           ge;
            assign sh        = {cur.sq_rem[SQW-3:0], cur.sq_v[MW-1-2*k -: 2]};
            assign tt        = SQW'({cur.sq_root, 2'b01});
            assign ge        = (sh >= tt);
            assign sq_rem_n  = ge ? sh - tt : sh;
            assign sq_root_n = {cur.sq_root[DW-2:0], ge};
        end
        else
        begin : g_nosq
            assign sq_rem_n  = cur.sq_rem;
            assign sq_root_n = cur.sq_root;
        end

        always_comb
        begin
            nxt         = cur;
            nxt.rem_re  = ge_re ? t_re - RW'(cur.den) : t_re;
            nxt.rem_im  = ge_im ? t_im - RW'(cur.den) : t_im;
            nxt.q_re    = {cur.q_re[QW-2:0], ge_re};
            nxt.q_im    = {cur.q_im[QW-2:0], ge_im};
            nxt.sq_rem  = sq_rem_n;
            nxt.sq_root = sq_root_n;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pipe_reg[k+1] <= nxt;
            end
        end
    end

    always_comb
    begin
        st_t           f;
        sres_t         rr;
        sres_t         ri;
        logic [QW-1:0] qr;
        logic [QW-1:0] qi;
        f  = pipe_reg[QW];
        qr = f.ovf_re ? '1 : f.q_re;
        qi = f.ovf_im ? '1 : f.q_im;
        rr = '0;
        ri = '0;
        out_item_next.is_equal = 1'b0;
        out_item_next.status   = ST_OK;
        case (f.h.op)
            OP_ADD, OP_SUB, OP_CONJ, OP_NEG:
            begin
                rr.val = f.h.sre;
                ri.val = f.h.sim;
                rr.sat = f.h.ssat;
            end
            OP_MUL:
            begin
                rr = sat_sm(f.neg_re, f.mul_re);
                ri = sat_sm(f.neg_im, f.mul_im);
            end
            OP_DIV:
            begin
                if (!f.h.dz)
                begin
                    rr = sat_sm(f.neg_re, MW'(qr));
                    ri = sat_sm(f.neg_im, MW'(qi));
                end
            end
            OP_MAG:
            begin
                rr = sat_sm(1'b0, MW'(f.sq_root));
            end
            default:
            begin
                out_item_next.is_equal = f.h.eq;
            end
        endcase
        out_item_next.res_re = rr.val;
        out_item_next.res_im = ri.val;
        if ((f.h.op == OP_DIV) && f.h.dz)
        begin
            out_item_next.status = ST_DIVZ;
        end
        else if (rr.sat || ri.sat)
        begin
            out_item_next.status = ST_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            pvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= pop;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            pvld_reg      <= {pvld_reg[QW-1:0], s3_vld_reg};
            out_valid_reg <= pvld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            pipe_reg[0]  <= pipe0_next;
            out_item_reg <= out_item_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/complex_arith_unit.sv =====
// Top level of the complex arithmetic unit: front end, item queue, back end.
// Depends on cau_pkg, cau_front, cau_queue, cau_back.
`timescale 1ns / 1ps
`default_nettype none

// Complex ALU on Q7.8 operands: add, subtract, multiply, divide, conjugate,
// negate, magnitude and compare. One item is accepted per cycle and one
// result leaves per cycle while out_ready is held high; every operation takes
// the same path, through the 17-step pipelined restoring divider that also
// carries the 16-step root.
// A queue of QUEUE_DEPTH items decouples input and output stalls.
module complex_arith_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cau_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cau_pkg::out_item_t      out_item
);
    import cau_pkg::*;

    fifo_stat_t fifo_stat;
    cls_item_t  push_item;
    cls_item_t  head;
    logic       push;
    logic       pop;

    cau_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_item (push_item)
    );

    cau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    cau_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cau_checker.sv =====
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arith_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "complex_arith_unit_assert.svh"

module cau_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire cau_pkg::in_item_t  in_item,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire cau_pkg::out_item_t out_item
);
    import cau_pkg::*;

    `CAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `CAU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item))
    `CAU_ASSERT_SAME(a_divz_zero, out_valid && (out_item.status == ST_DIVZ), (out_item.res_re == '0) && (out_item.res_im == '0) && !out_item.is_equal)
    `CAU_ASSERT_SAME(a_eq_clean, out_valid && out_item.is_equal, (out_item.status == ST_OK) && (out_item.res_re == '0) && (out_item.res_im == '0))

    logic unused_in;
    assign unused_in = in_valid ^ in_ready ^ (^in_item);

endmodule

bind complex_arith_unit cau_checker u_cau_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
